[rtl/core/coalescent_tree_event_step_core_defines.svh]
// assertion macros shared by the coalescent tree event step rtl
`ifndef COALESCENT_TREE_EVENT_STEP_CORE_DEFINES_SVH
`define COALESCENT_TREE_EVENT_STEP_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define CTES_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CTES_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define CTES_ASSERT(lbl, prop, msg)
`define CTES_NEVER(lbl, expr, msg)
`endif

`endif

[rtl/core/ctes_pkg.sv]
// types, constants and codes of the coalescent tree event step core
package ctes_pkg;

  localparam int MAX_SAMPLE = 64;
  localparam int PATH_LEN   = 25;
  localparam int SEQ_AW     = $clog2(MAX_SAMPLE);
  localparam int CNT_W      = 7;
  localparam int MULT_W     = 7;
  localparam int PATH_W     = 5;
  localparam int ENT_W      = PATH_W + MULT_W;
  localparam int DRAW_W     = 15;
  localparam int THETA_W    = 16;
  localparam int SITE_W     = 12;
  localparam int OP_B_W     = 17;
  localparam int PROD_W     = DRAW_W + OP_B_W;
  localparam int FRAC_W     = 8;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_TUSER_W = 3;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CNT_W-1:0]   SAMPLE_RESET = 7'd2;
  localparam logic [THETA_W-1:0] THETA_RESET  = 16'd256;
  localparam logic [ENT_W-1:0]   ENT_RESET    = {5'd1, 7'd2};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_SIZE = 1'b0,
    CFG_THETA_Q     = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    STAT_LINEAGE    = 3'd0,
    STAT_MUT_SINGLE = 3'd1,
    STAT_SPLIT      = 3'd2,
    STAT_COMPLETE   = 3'd3,
    STAT_PATH_FULL  = 3'd4,
    STAT_IGNORED    = 3'd5,
    STAT_RESTARTED  = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    PH_RUN  = 2'd0,
    PH_DONE = 2'd1,
    PH_ERR  = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_CHECK,
    S_EVENT,
    S_SPLIT,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic              mul_en;
    logic [DRAW_W-1:0] a;
    logic [OP_B_W-1:0] b;
    logic [CNT_W-1:0]  cmp_k;
    logic              cmp_scale;
  } alu_req_t;

  typedef struct packed {
    logic              we;
    logic [SEQ_AW-1:0] waddr;
    logic [ENT_W-1:0]  wdata;
    logic              re;
    logic [SEQ_AW-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    status_t           status;
    logic [SEQ_AW-1:0] seq_index;
    logic [SEQ_AW-1:0] new_seq_index;
    logic [SITE_W-1:0] site_number;
    logic [CNT_W-1:0]  lineages;
    logic              tree_done;
  } result_t;

endpackage

[rtl/core/ctes_ram.sv]
// generic single write port ram with registered read
module ctes_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/ctes_alu.sv]
// shared multiply and scaled compare unit
module ctes_alu (
  input  logic              clk,
  input  ctes_pkg::alu_req_t req,
  output logic              gt
);
  import ctes_pkg::*;

  localparam int KV_W = CNT_W + DRAW_W;

  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] prod_nxt;
  logic [KV_W-1:0]   kv;
  logic [PROD_W-1:0] bound;

  assign prod_nxt = PROD_W'(req.a) * PROD_W'(req.b);

  // full scale times k, optionally shifted into q8.8
  assign kv    = {req.cmp_k, {DRAW_W{1'b0}}} - KV_W'(req.cmp_k);
  assign bound = req.cmp_scale ? PROD_W'({kv, {FRAC_W{1'b0}}}) : PROD_W'(kv);
  assign gt    = prod_r > bound;

  always_ff @(posedge clk) begin
    if (req.mul_en) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

[rtl/core/ctes_ctrl.sv]
// sequencer and tree state of the coalescent tree event step core
`include "coalescent_tree_event_step_core_defines.svh"

module ctes_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_mode,
  input  logic [ctes_pkg::DRAW_W-1:0]     in_pick,
  input  logic [ctes_pkg::DRAW_W-1:0]     in_event,
  input  logic [ctes_pkg::CNT_W-1:0]      sample_size,
  input  logic [ctes_pkg::THETA_W-1:0]    theta_q,
  output ctes_pkg::alu_req_t              alu_req,
  input  logic                            alu_gt,
  output ctes_pkg::ram_req_t              ram_req,
  input  logic [ctes_pkg::ENT_W-1:0]      ram_rdata,
  output logic                            res_valid,
  input  logic                            res_ready,
  output ctes_pkg::result_t               res
);
  import ctes_pkg::*;

  state_t            state_r, state_nxt;
  logic              mode_r, mode_nxt;
  logic [DRAW_W-1:0] pick_r, pick_nxt;
  logic [DRAW_W-1:0] event_r, event_nxt;
  logic [SEQ_AW-1:0] j_r, j_nxt;
  logic [CNT_W-1:0]  sum_r, sum_nxt;
  logic [CNT_W-1:0]  lineage_r, lineage_nxt;
  logic [CNT_W-1:0]  seq_count_r, seq_count_nxt;
  logic [SITE_W-1:0] next_site_r, next_site_nxt;
  phase_t            phase_r, phase_nxt;
  logic              fresh0_r, fresh0_nxt;
  status_t           status_r, status_nxt;
  logic [SEQ_AW-1:0] made_r, made_nxt;
  logic [SITE_W-1:0] site_r, site_nxt;

  logic [ENT_W-1:0]  ent;
  logic [MULT_W-1:0] mult_cur;
  logic [PATH_W-1:0] path_cur;
  logic [CNT_W-1:0]  sum_add;
  logic [CNT_W-1:0]  j_inc;
  logic [CNT_W-1:0]  mm;
  logic [CNT_W-1:0]  n_cap;
  logic [OP_B_W-1:0] opb;
  logic              more;
  logic              path_full;
  logic              can_split;
  logic              grow;
  logic              early_stop;

  // entry 0 reads as its reset value until first written
  assign ent      = (fresh0_r && (j_r == '0)) ? ENT_RESET : ram_rdata;
  assign mult_cur = ent[MULT_W-1:0];
  assign path_cur = ent[ENT_W-1:MULT_W];

  assign sum_add    = sum_r + CNT_W'(mult_cur);
  assign j_inc      = CNT_W'(j_r) + CNT_W'(1);
  assign more       = alu_gt && (j_inc < seq_count_r);
  assign mm         = lineage_r - CNT_W'(1);
  assign n_cap      = (sample_size > CNT_W'(MAX_SAMPLE)) ? CNT_W'(MAX_SAMPLE) : sample_size;
  assign opb        = OP_B_W'({mm, {FRAC_W{1'b0}}}) + OP_B_W'(theta_q);
  assign path_full  = path_cur >= PATH_W'(PATH_LEN - 1);
  assign can_split  = (mult_cur != MULT_W'(1)) && (seq_count_r < CNT_W'(MAX_SAMPLE));
  assign grow       = lineage_r < n_cap;
  assign early_stop = mode_r || (phase_r != PH_RUN) || (lineage_r > n_cap);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        state_nxt = early_stop ? S_EMIT : S_SCAN;
      end
      S_SCAN: begin
        if (!more) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        state_nxt = path_full ? S_EMIT : S_EVENT;
      end
      S_EVENT: begin
        state_nxt = (alu_gt && can_split) ? S_SPLIT : S_EMIT;
      end
      S_SPLIT: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (res_ready) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    res_valid = 1'b0;
    alu_req   = '0;
    ram_req   = '0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
      end
      S_DECIDE: begin
        alu_req.mul_en = 1'b1;
        alu_req.a      = pick_r;
        alu_req.b      = OP_B_W'(lineage_r);
        ram_req.re     = 1'b1;
        ram_req.raddr  = '0;
      end
      S_SCAN: begin
        alu_req.cmp_k = sum_add;
        ram_req.re    = more;
        ram_req.raddr = j_inc[SEQ_AW-1:0];
      end
      S_CHECK: begin
        alu_req.mul_en = 1'b1;
        alu_req.a      = event_r;
        alu_req.b      = opb;
      end
      S_EVENT: begin
        alu_req.cmp_k     = mm;
        alu_req.cmp_scale = 1'b1;
        if (alu_gt) begin
          ram_req.we = 1'b1;
          if (can_split) begin
            ram_req.waddr = seq_count_r[SEQ_AW-1:0];
            ram_req.wdata = {path_cur + PATH_W'(1), MULT_W'(1)};
          end else begin
            ram_req.waddr = j_r;
            ram_req.wdata = {path_cur + PATH_W'(1), mult_cur};
          end
        end else if (grow) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = j_r;
          ram_req.wdata = {path_cur, mult_cur + MULT_W'(1)};
        end
      end
      S_SPLIT: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = j_r;
        ram_req.wdata = {path_cur, mult_cur - MULT_W'(1)};
      end
      S_EMIT: begin
        res_valid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res.status        = status_r;
    res.seq_index     = j_r;
    res.new_seq_index = made_r;
    res.site_number   = site_r;
    res.lineages      = lineage_r;
    res.tree_done     = phase_r != PH_RUN;
  end

  always_comb begin
    mode_nxt      = mode_r;
    pick_nxt      = pick_r;
    event_nxt     = event_r;
    j_nxt         = j_r;
    sum_nxt       = sum_r;
    lineage_nxt   = lineage_r;
    seq_count_nxt = seq_count_r;
    next_site_nxt = next_site_r;
    phase_nxt     = phase_r;
    fresh0_nxt    = fresh0_r;
    status_nxt    = status_r;
    made_nxt      = made_r;
    site_nxt      = site_r;
    if (ram_req.we && (ram_req.waddr == '0)) fresh0_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mode_nxt  = in_mode;
          pick_nxt  = in_pick;
          event_nxt = in_event;
        end
      end
      S_DECIDE: begin
        j_nxt    = '0;
        sum_nxt  = '0;
        made_nxt = '0;
        site_nxt = '0;
        if (mode_r) begin
          lineage_nxt   = CNT_W'(2);
          seq_count_nxt = CNT_W'(1);
          next_site_nxt = SITE_W'(1);
          phase_nxt     = PH_RUN;
          fresh0_nxt    = 1'b1;
          status_nxt    = STAT_RESTARTED;
        end else if (phase_r != PH_RUN) begin
          status_nxt = STAT_IGNORED;
        end else if (lineage_r > n_cap) begin
          phase_nxt  = PH_DONE;
          status_nxt = STAT_COMPLETE;
        end
      end
      S_SCAN: begin
        if (more) begin
          j_nxt   = j_inc[SEQ_AW-1:0];
          sum_nxt = sum_add;
        end
      end
      S_CHECK: begin
        if (path_full) begin
          phase_nxt  = PH_ERR;
          status_nxt = STAT_PATH_FULL;
        end
      end
      S_EVENT: begin
        if (alu_gt) begin
          site_nxt      = next_site_r;
          next_site_nxt = next_site_r + SITE_W'(1);
          if (can_split) begin
            made_nxt      = seq_count_r[SEQ_AW-1:0];
            seq_count_nxt = seq_count_r + CNT_W'(1);
            status_nxt    = STAT_SPLIT;
          end else begin
            status_nxt = STAT_MUT_SINGLE;
          end
        end else if (grow) begin
          lineage_nxt = lineage_r + CNT_W'(1);
          status_nxt  = STAT_LINEAGE;
        end else begin
          lineage_nxt = lineage_r + CNT_W'(1);
          phase_nxt   = PH_DONE;
          status_nxt  = STAT_COMPLETE;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lineage_r   <= CNT_W'(2);
      seq_count_r <= CNT_W'(1);
      next_site_r <= SITE_W'(1);
      phase_r     <= PH_RUN;
      fresh0_r    <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      lineage_r   <= lineage_nxt;
      seq_count_r <= seq_count_nxt;
      next_site_r <= next_site_nxt;
      phase_r     <= phase_nxt;
      fresh0_r    <= fresh0_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r   <= mode_nxt;
    pick_r   <= pick_nxt;
    event_r  <= event_nxt;
    j_r      <= j_nxt;
    sum_r    <= sum_nxt;
    status_r <= status_nxt;
    made_r   <= made_nxt;
    site_r   <= site_nxt;
  end

  `CTES_ASSERT(a_seq_count_range,
               (seq_count_r != '0) && (seq_count_r <= CNT_W'(MAX_SAMPLE)),
               "sequence count out of range")
  `CTES_ASSERT(a_scan_in_range,
               (state_r == S_SCAN) |-> (CNT_W'(j_r) < seq_count_r),
               "scan index beyond stored sequences")
  `CTES_ASSERT(a_res_held,
               (res_valid && !res_ready) |=> (res_valid && $stable(res)),
               "result lost while stalled")
  `CTES_ASSERT(a_write_states,
               ram_req.we |-> ((state_r == S_EVENT) || (state_r == S_SPLIT)),
               "memory written outside an update step")
  `CTES_NEVER(a_split_slot, (state_r == S_SPLIT) && (made_r == '0),
              "split wrote over the first sequence")

endmodule

[rtl/core/coalescent_tree_event_step_core.sv]
// top level of the coalescent tree event step core
// One word in, one word out. A restart, or a draw that finds the tree stopped or the sample
// size already passed, goes from the decide step straight to its result.
// A draw walks up to k stored sequences (1 to 64) one memory entry per cycle, and one shared
// multiply and compare unit settles both the pick and the mutation test. The draw passes
// the decide, scan, check and event steps, skips the event step when the path is full and
// adds a split step for a split. The core takes no new word until the current one is
// finished, but a finished result waits in the output register without holding up the
// next word; a second result waits until that register is read. Configuration must be
// written through the cfg port while idle; the core itself does not enforce this.
module coalescent_tree_event_step_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // pick_draw [14:0], event_draw [29:15], zero [31:30]
  input  logic [ctes_pkg::IN_TDATA_W-1:0]      in_tdata,
  // mode [0]
  input  logic                                 in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // seq_index [5:0], new_seq_index [11:6], site_number [23:12], lineages [30:24],
  // tree_done [31]
  output logic [ctes_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // status [2:0]
  output logic [ctes_pkg::OUT_TUSER_W-1:0]     out_tuser,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ctes_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ctes_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import ctes_pkg::*;

  logic [CNT_W-1:0]   sample_size_r, sample_size_nxt;
  logic [THETA_W-1:0] theta_q_r, theta_q_nxt;
  logic               out_valid_r, out_valid_nxt;
  result_t            out_res_r, out_res_nxt;

  alu_req_t           alu_req;
  logic               alu_gt;
  ram_req_t           ram_req;
  logic [ENT_W-1:0]   ram_rdata;
  logic               res_valid;
  logic               res_ready;
  result_t            res;

  assign cfg_ready = 1'b1;
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    sample_size_nxt = sample_size_r;
    theta_q_nxt     = theta_q_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_SAMPLE_SIZE: sample_size_nxt = cfg_data[CNT_W-1:0];
        CFG_THETA_Q:     theta_q_nxt     = cfg_data[THETA_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (out_tready) out_valid_nxt = 1'b0;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_size_r <= SAMPLE_RESET;
      theta_q_r     <= THETA_RESET;
      out_valid_r   <= 1'b0;
    end else begin
      sample_size_r <= sample_size_nxt;
      theta_q_r     <= theta_q_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {out_res_r.tree_done, out_res_r.lineages, out_res_r.site_number,
                       out_res_r.new_seq_index, out_res_r.seq_index};

  ctes_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_mode     (in_tuser),
    .in_pick     (in_tdata[DRAW_W-1:0]),
    .in_event    (in_tdata[2*DRAW_W-1:DRAW_W]),
    .sample_size (sample_size_r),
    .theta_q     (theta_q_r),
    .alu_req     (alu_req),
    .alu_gt      (alu_gt),
    .ram_req     (ram_req),
    .ram_rdata   (ram_rdata),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  ctes_alu u_alu (
    .clk (clk),
    .req (alu_req),
    .gt  (alu_gt)
  );

  ctes_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_SAMPLE)
  ) u_seq_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

endmodule
